// ----- rtl/turtle_graphics_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Turtle graphics engine assertion macros
// Shared property wrappers for the checker, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TURTLE_GRAPHICS_ENGINE_UNIT_DEFINES_SVH
`define TURTLE_GRAPHICS_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tge_pkg.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine package
// Request and result types, command codes, controller interface structs,
// fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tge_pkg;

    // Command codes carried in the action field.
    localparam logic [2:0] ACT_FORWARD  = 3'd0;
    localparam logic [2:0] ACT_BACKWARD = 3'd1;
    localparam logic [2:0] ACT_LEFT     = 3'd2;
    localparam logic [2:0] ACT_RIGHT    = 3'd3;
    localparam logic [2:0] ACT_PEN_UP   = 3'd4;
    localparam logic [2:0] ACT_PEN_DOWN = 3'd5;
    localparam logic [2:0] ACT_HOME     = 3'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

    // CORDIC sizing: rotation vector width, angle width, rounded delta width.
    localparam int CORDIC_STEPS = 32;
    localparam int STEP_W       = 5;
    localparam int CW           = 52;
    localparam int ZW           = 34;
    localparam int GUARD        = 16;
    localparam int DXW          = CW - GUARD;
    localparam int SW           = DXW + 1;
    localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;

    // Degree to binary angle conversion: (|amount| * 2^16 + 180) / 360 by
    // reciprocal multiplication. Since 360 = 8 * 45, both divisions drop three
    // bits and multiply by RECIP_45 = ceil(2^35 / 45), exact below 2^29.
    localparam int DIV_STEPS   = 3;
    localparam int RECIP_SHIFT = 35;
    localparam int QUO_W       = 23;
    localparam int REM_W       = 9;
    localparam int FRAC_W      = 16;
    localparam logic [29:0]      RECIP_45   = 30'd763549742;
    localparam logic [REM_W-1:0] TURN_DENOM = 9'd360;
    localparam logic [21:0]      FRAC_BIAS  = 22'd22;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] amount;
    } tge_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        direction;
        logic               pen_is_lowered;
        logic               line_valid;
        logic signed [31:0] line_from_x;
        logic signed [31:0] line_from_y;
        logic               saturated;
    } tge_res_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_LOAD,
        OP_ITER,
        OP_ROUND,
        OP_DIV,
        OP_COMMIT
    } tge_op_t;

    typedef struct packed {
        logic              capture;
        tge_op_t           op;
        logic [STEP_W-1:0] step;
    } tge_cmd_t;

    typedef struct packed {
        logic is_move;
        logic is_turn;
    } tge_status_t;

    // Arctangent of 2^-i as a binary angle.
    function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            5'd31: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/tge_ctrl.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine controller
// Sequences one request at a time through the datapath: dispatch, CORDIC
// load and iterations, rounding, division steps and the final commit.
// ----------------------------------------------------------------------------
module tge_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tge_pkg::tge_status_t status,
    output tge_pkg::tge_cmd_t    cmd
);
    import tge_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_ITER,
        S_ROUND,
        S_DIV,
        S_COMMIT
    } state_t;

    localparam logic [STEP_W-1:0] ITER_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              commit_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign commit_ok = !out_valid_reg || out_ready;

    // Next state, step counter and command decode.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.op         = OP_NONE;
        cmd.step       = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.op    = OP_MUL;
                step_next = '0;
                priority if (status.is_move)
                    state_next = S_LOAD;
                else if (status.is_turn)
                    state_next = S_DIV;
                else
                    state_next = S_COMMIT;
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                step_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.op    = OP_ITER;
                step_next = step_reg + 1'b1;
                if (step_reg == ITER_LAST)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.op     = OP_ROUND;
                state_next = S_COMMIT;
            end
            S_DIV:
            begin
                cmd.op    = OP_DIV;
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_ok)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/tge_datapath.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine datapath
// Turtle state, home registers, gain multiplier, shared CORDIC rotator,
// reciprocal-multiply conversion of degrees and the result register.
// ----------------------------------------------------------------------------
module tge_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tge_pkg::tge_req_t           in_data,
    input  logic                        cfg_we,
    input  logic [tge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                 cfg_data,
    input  tge_pkg::tge_cmd_t           cmd,
    output tge_pkg::tge_status_t        status,
    output tge_pkg::tge_res_t           out_data
);
    import tge_pkg::*;

    // Home registers and turtle state.
    logic [31:0]        start_x_reg, start_y_reg, start_h_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic [31:0]        cur_h_reg;
    logic               pen_reg;

    // Working registers of the current request.
    logic [2:0]            act_reg;
    logic                  neg_reg;
    logic [31:0]           mag_reg;
    logic [63:0]           prod_reg;
    logic signed [CW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [FRAC_W-1:0]     frac_reg;
    tge_res_t              res_reg;

    logic                  cap_neg;
    logic [31:0]           cap_mag;
    logic [63:0]           prod_next;
    logic [47:0]           prod_hi;
    logic                  fold_pos, fold_neg, load_neg;
    logic [CW-1:0]         load_base;
    logic signed [CW-1:0]  x_init;
    logic signed [ZW-1:0]  z_ext, z_init;
    logic signed [CW-1:0]  x_shr, y_shr;
    logic signed [ZW-1:0]  atan_z;
    logic signed [CW-1:0]  x_rnd, y_rnd;
    logic [58:0]           quo_prod;
    logic [31:0]           quo_x360;
    logic [31:0]           rem_full;
    logic [21:0]           frac_num;
    logic [51:0]           frac_prod;
    logic [SW-1:0]         sum_x, sum_y;
    logic [32:0]           clip_x, clip_y;
    logic [31:0]           h_delta;
    logic                  h_sub;
    tge_res_t              res_next;
    logic signed [31:0]    cx_next, cy_next;
    logic [31:0]           ch_next;
    logic                  pen_next;

    // Clamp a widened coordinate to 32 signed bits; the top bit flags a clip.
    function automatic logic [32:0] clip32(input logic [SW-1:0] s);
        logic ovf;
        logic [31:0] v;
        ovf = !((&s[SW-1:31]) || !(|s[SW-1:31]));
        v   = ovf ? (s[SW-1] ? 32'h80000000 : 32'h7FFFFFFF) : s[31:0];
        return {ovf, v};
    endfunction

    assign status.is_move = (act_reg == ACT_FORWARD) || (act_reg == ACT_BACKWARD);
    assign status.is_turn = (act_reg == ACT_LEFT) || (act_reg == ACT_RIGHT);
    assign out_data       = res_reg;

    // Capture: magnitude of the amount and sign of the signed distance or turn.
    always_comb
    begin
        cap_mag = in_data.amount[31] ? (~in_data.amount + 32'd1) : in_data.amount;
        if (in_data.action == ACT_BACKWARD)
            cap_neg = (in_data.amount != 32'sd0) && !in_data.amount[31];
        else
            cap_neg = in_data.amount[31];
    end

    // Gain prescale product.
    assign prod_next = 64'(mag_reg) * 64'(CORDIC_GAIN);

    // CORDIC load: round off the guard bits, apply sign and half-turn fold.
    always_comb
    begin
        prod_hi   = prod_reg[63:16];
        fold_pos  = $signed(cur_h_reg) > $signed(32'h40000000);
        fold_neg  = $signed(cur_h_reg) < $signed(32'hC0000000);
        load_neg  = neg_reg ^ (fold_pos || fold_neg);
        load_base = load_neg ? {{(CW-48){1'b1}}, ~prod_hi} : {{(CW-48){1'b0}}, prod_hi};
        x_init    = $signed(load_base + CW'(load_neg ? !prod_reg[15] : prod_reg[15]));
        z_ext     = $signed({{(ZW-32){cur_h_reg[31]}}, cur_h_reg});
        priority if (fold_pos)
            z_init = z_ext - $signed(ZW'(33'h080000000));
        else if (fold_neg)
            z_init = z_ext + $signed(ZW'(33'h080000000));
        else
            z_init = z_ext;
    end

    // One rotation step and final rounding.
    always_comb
    begin
        x_shr  = x_reg >>> cmd.step;
        y_shr  = y_reg >>> cmd.step;
        atan_z = $signed({{(ZW-32){1'b0}}, cordic_atan(cmd.step)});
        x_rnd  = x_reg + $signed(CW'(32768));
        y_rnd  = y_reg + $signed(CW'(32768));
    end

    // Turn conversion in three registered stages: whole multiples of 360,
    // the remainder, then the rounded fraction of the remainder times 2^16.
    always_comb
    begin
        quo_prod  = 59'(mag_reg[31:3]) * 59'(RECIP_45);
        quo_x360  = 32'(quo_reg) * 32'(TURN_DENOM);
        rem_full  = mag_reg - quo_x360;
        frac_num  = {rem_reg, 13'd0} + FRAC_BIAS;
        frac_prod = 52'(frac_num) * 52'(RECIP_45);
    end

    // Commit: new turtle state and the result of the request.
    always_comb
    begin
        sum_x    = {{(SW-32){cur_x_reg[31]}}, cur_x_reg} + {dx_reg[DXW-1], dx_reg};
        sum_y    = {{(SW-32){cur_y_reg[31]}}, cur_y_reg} + {dy_reg[DXW-1], dy_reg};
        clip_x   = clip32(sum_x);
        clip_y   = clip32(sum_y);
        h_delta  = {quo_reg[15:0], frac_reg};
        h_sub    = (act_reg == ACT_LEFT) ^ neg_reg;
        cx_next  = cur_x_reg;
        cy_next  = cur_y_reg;
        ch_next  = cur_h_reg;
        pen_next = pen_reg;
        res_next = '0;
        unique case (act_reg)
            ACT_FORWARD, ACT_BACKWARD:
            begin
                cx_next              = $signed(clip_x[31:0]);
                cy_next              = $signed(clip_y[31:0]);
                res_next.saturated   = clip_x[32] || clip_y[32];
                res_next.line_valid  = pen_reg;
                res_next.line_from_x = pen_reg ? cur_x_reg : 32'sd0;
                res_next.line_from_y = pen_reg ? cur_y_reg : 32'sd0;
            end
            ACT_LEFT, ACT_RIGHT:
            begin
                ch_next = h_sub ? (cur_h_reg - h_delta) : (cur_h_reg + h_delta);
            end
            ACT_PEN_UP:
            begin
                pen_next = 1'b0;
            end
            ACT_PEN_DOWN:
            begin
                pen_next = 1'b1;
            end
            ACT_HOME:
            begin
                cx_next = $signed(start_x_reg);
                cy_next = $signed(start_y_reg);
                ch_next = start_h_reg;
            end
            default:
            begin
                cx_next = cur_x_reg;
            end
        endcase
        res_next.pos_x          = cx_next;
        res_next.pos_y          = cy_next;
        res_next.direction      = ch_next;
        res_next.pen_is_lowered = pen_next;
    end

    // Architectural state: home registers and turtle position, heading, pen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_h_reg <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_h_reg   <= '0;
            pen_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_X:       start_x_reg <= cfg_data;
                    CFG_START_Y:       start_y_reg <= cfg_data;
                    CFG_START_HEADING: start_h_reg <= cfg_data;
                    default:           start_x_reg <= start_x_reg;
                endcase
            end
            if (cmd.op == OP_COMMIT)
            begin
                cur_x_reg <= cx_next;
                cur_y_reg <= cy_next;
                cur_h_reg <= ch_next;
                pen_reg   <= pen_next;
            end
        end
    end

    // Working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_data.action;
            neg_reg <= cap_neg;
            mag_reg <= cap_mag;
        end
        unique case (cmd.op)
            OP_MUL:
            begin
                prod_reg <= prod_next;
            end
            OP_LOAD:
            begin
                x_reg <= x_init;
                y_reg <= '0;
                z_reg <= z_init;
            end
            OP_ITER:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - y_shr;
                    y_reg <= y_reg + x_shr;
                    z_reg <= z_reg - atan_z;
                end
                else
                begin
                    x_reg <= x_reg + y_shr;
                    y_reg <= y_reg - x_shr;
                    z_reg <= z_reg + atan_z;
                end
            end
            OP_ROUND:
            begin
                dx_reg <= x_rnd[CW-1:GUARD];
                dy_reg <= y_rnd[CW-1:GUARD];
            end
            OP_DIV:
            begin
                // Each stage settles in the cycle after the one it reads.
                quo_reg  <= quo_prod[RECIP_SHIFT +: QUO_W];
                rem_reg  <= rem_full[REM_W-1:0];
                frac_reg <= frac_prod[RECIP_SHIFT +: FRAC_W];
            end
            OP_COMMIT:
            begin
                res_reg <= res_next;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule

// ----- rtl/turtle_graphics_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine unit
// Executes turtle commands on a Q16.16 position, a binary-angle heading and
// a pen flag, returning one result request per command.
//
// Channels: in_valid/in_ready carry a command request (action, amount);
// out_valid/out_ready carry the result request; cfg_valid/cfg_ready write
// the home registers (start_x, start_y, start_heading) and are always ready.
// Commands run one at a time. A move runs from accept to the next accept
// through dispatch, gain multiply, CORDIC load, 32 rotation steps of
// the single shared shift-add rotator, rounding and commit. A turn runs
// through dispatch, three reciprocal-multiply stages of the divide by
// 360, and commit. Pen and home commands go from dispatch to commit. The
// result appears in the same cycle that the next accept becomes possible.
// The result sits in an output register, so a new command is accepted
// while the previous result is still unread; a command only waits at
// commit while that register is full and out_ready is low.
// Reset puts the turtle at (0, 0), heading 0, pen down, home registers 0.
// ----------------------------------------------------------------------------
module turtle_graphics_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tge_pkg::tge_req_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tge_pkg::tge_res_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import tge_pkg::*;

    tge_cmd_t    cmd;
    tge_status_t status;

    // Configuration writes are always accepted and registered on the next clock edge.
    assign cfg_ready = 1'b1;

    // Sequencer.
    tge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and state.
    tge_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/tge_checker.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine checker
// Port-level properties of the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "turtle_graphics_engine_unit_defines.svh"

module tge_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input tge_pkg::tge_res_t             out_data
);
    import tge_pkg::*;

    // A stalled result stays put.
    `TGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // Only one command is in flight at a time.
    `TGE_ASSERT_NEXT(a_single_cmd, in_valid && in_ready, !in_ready, "second command taken while busy")

    // A drawn segment implies the pen is down.
    `TGE_ASSERT_SAME(a_line_pen, out_valid && out_data.line_valid, out_data.pen_is_lowered, "segment reported with pen up")

    // Without a segment, the start point reads zero.
    `TGE_ASSERT_SAME(a_line_zero, out_valid && !out_data.line_valid, out_data.line_from_x == 32'sd0 && out_data.line_from_y == 32'sd0, "segment start set without segment")

endmodule

bind turtle_graphics_engine_unit tge_checker u_tge_checker (.*);

// ----- tb/tb_turtle_graphics_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Turtle graphics engine unit testbench
// Sends turtle command requests through a bursty driver and checks every
// result request against a cycle-free model of the turtle: CORDIC moves,
// degree turns, pen changes, home loads and saturation. Home registers are
// rewritten between phases while the unit is idle, including extreme values.
// ----------------------------------------------------------------------------
module tb_turtle_graphics_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tge_pkg::*;

    // Codes and constants of the testbench.
    localparam logic [2:0]           ACT_UNUSED     = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd3;
    localparam int                   CYCLE_LIMIT    = 600000;
    localparam int                   RANDOM_PER_SET = 110;
    localparam longint               COORD_MAX      = 64'sd2147483647;
    localparam longint               COORD_MIN      = -64'sd2147483648;
    localparam longint               QUARTER_TURN   = 64'sd1073741824;
    localparam longint               HALF_TURN      = 64'sd2147483648;
    localparam longint unsigned      ROTATOR_GAIN   = 64'd2608131496;
    localparam logic signed [31:0]   AMT_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   AMT_MIN        = 32'sh8000_0000;

    // Arctangent of 2^-i as a binary angle, entry 0 in the top word.
    localparam logic [32*32-1:0] ATAN_STEPS = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Clock, reset and the unit's ports.
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    tge_req_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    tge_res_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Turtle state and home registers as the testbench tracks them.
    logic signed [31:0] trt_x       = '0;
    logic signed [31:0] trt_y       = '0;
    logic [31:0]        trt_heading = '0;
    logic               trt_pen     = 1'b1;
    logic signed [31:0] home_x      = '0;
    logic signed [31:0] home_y      = '0;
    logic [31:0]        home_heading = '0;

    // Commands waiting to be sent and results still owed by the unit.
    tge_req_t cmd_backlog[$];
    tge_res_t turtle_results_due[$];

    // Run statistics.
    int fail_count      = 0;
    int cmds_sent       = 0;
    int moves_sent      = 0;
    int segments_drawn  = 0;
    int clipped_moves   = 0;
    int results_checked = 0;
    int reg_writes      = 0;

    // Sender burst state and receiver stall state.
    int   burst_left = 0;
    int   gap_left   = 0;
    int   hold_cnt   = 0;
    logic rx_open    = 1'b0;

    turtle_graphics_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Degrees in Q16.16 to a binary angle, rounded half away from zero.
    function automatic logic [31:0] turn_delta(input logic signed [31:0] deg);
        longint          sd;
        longint unsigned mag;
        longint unsigned quo;
        logic [31:0]     q;
        sd  = deg;
        mag = (sd < 0) ? -sd : sd;
        quo = (mag * 64'd65536 + 64'd180) / 64'd360;
        q   = quo[31:0];
        return (sd < 0) ? (32'd0 - q) : q;
    endfunction

    // Clamp a coordinate to the signed 32-bit range and flag any clipping.
    function automatic logic signed [31:0] clamp_coord(input longint v, inout logic sat);
        if (v > COORD_MAX)
        begin
            sat = 1'b1;
            v   = COORD_MAX;
        end
        else if (v < COORD_MIN)
        begin
            sat = 1'b1;
            v   = COORD_MIN;
        end
        return v[31:0];
    endfunction

    // Apply one command to the tracked turtle and return the result it owes.
    function automatic tge_res_t step_turtle(input tge_req_t req);
        tge_res_t        res;
        logic            sat;
        longint          travel;
        longint unsigned mag;
        longint          cx;
        longint          cy;
        longint          cz;
        longint          xs;
        longint          ys;
        longint          dx;
        longint          dy;
        res = '0;
        sat = 1'b0;
        cmds_sent++;
        case (req.action)
            ACT_FORWARD, ACT_BACKWARD:
            begin
                moves_sent++;
                travel = longint'($signed(req.amount));
                if (req.action == ACT_BACKWARD)
                    travel = -travel;
                // Prescale the distance by the rotator gain into guard bits.
                mag = (travel < 0) ? -travel : travel;
                mag = (mag * ROTATOR_GAIN + 64'd32768) >> 16;
                cx  = (travel < 0) ? -longint'(mag) : longint'(mag);
                cy  = 0;
                cz  = longint'($signed(trt_heading));
                // Fold the heading into the right half plane.
                if (cz > QUARTER_TURN)
                begin
                    cx = -cx;
                    cz = cz - HALF_TURN;
                end
                else if (cz < -QUARTER_TURN)
                begin
                    cx = -cx;
                    cz = cz + HALF_TURN;
                end
                for (int i = 0; i < 32; i++)
                begin
                    xs = cx >>> i;
                    ys = cy >>> i;
                    if (cz >= 0)
                    begin
                        cx = cx - ys;
                        cy = cy + xs;
                        cz = cz - longint'(ATAN_STEPS[(31 - i) * 32 +: 32]);
                    end
                    else
                    begin
                        cx = cx + ys;
                        cy = cy - xs;
                        cz = cz + longint'(ATAN_STEPS[(31 - i) * 32 +: 32]);
                    end
                end
                dx = (cx + 64'sd32768) >>> 16;
                dy = (cy + 64'sd32768) >>> 16;
                // A move with the pen down reports where the segment starts.
                if (trt_pen)
                begin
                    res.line_valid  = 1'b1;
                    res.line_from_x = trt_x;
                    res.line_from_y = trt_y;
                    segments_drawn++;
                end
                trt_x = clamp_coord(longint'(trt_x) + dx, sat);
                trt_y = clamp_coord(longint'(trt_y) + dy, sat);
                if (sat)
                    clipped_moves++;
            end
            ACT_LEFT:     trt_heading = trt_heading - turn_delta(req.amount);
            ACT_RIGHT:    trt_heading = trt_heading + turn_delta(req.amount);
            ACT_PEN_UP:   trt_pen = 1'b0;
            ACT_PEN_DOWN: trt_pen = 1'b1;
            ACT_HOME:
            begin
                trt_x       = home_x;
                trt_y       = home_y;
                trt_heading = home_heading;
            end
            default: ;
        endcase
        res.pos_x          = trt_x;
        res.pos_y          = trt_y;
        res.direction      = trt_heading;
        res.pen_is_lowered = trt_pen;
        res.saturated      = sat;
        return res;
    endfunction

    function automatic logic signed [31:0] fx(input int whole);
        return whole <<< 16;
    endfunction

    function automatic string res_text(input tge_res_t r);
        return $sformatf("pos=(%h,%h) dir=%h pen=%b line=%b from=(%h,%h) sat=%b",
                         r.pos_x, r.pos_y, r.direction, r.pen_is_lowered,
                         r.line_valid, r.line_from_x, r.line_from_y, r.saturated);
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic queue_cmd(input logic [2:0] act, input logic signed [31:0] amt);
        tge_req_t req;
        req.action = act;
        req.amount = amt;
        cmd_backlog.push_back(req);
    endtask

    // Random command: mostly moves and turns, some pen, home and unused codes.
    function automatic tge_req_t random_cmd();
        tge_req_t req;
        int       pick;
        int       shape;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        if (pick < 46)
            req.action = $urandom_range(0, 1) ? ACT_BACKWARD : ACT_FORWARD;
        else if (pick < 76)
            req.action = $urandom_range(0, 1) ? ACT_RIGHT : ACT_LEFT;
        else if (pick < 88)
            req.action = $urandom_range(0, 1) ? ACT_PEN_DOWN : ACT_PEN_UP;
        else if (pick < 95)
            req.action = ACT_HOME;
        else
            req.action = ACT_UNUSED;
        if (shape < 25)
            req.amount = $urandom;
        else if (shape < 60)
            req.amount = $signed($urandom_range(0, 262144000)) - 131072000;
        else if (shape < 75)
            req.amount = $signed($urandom_range(0, 131070)) - 65535;
        else if (shape < 90)
            req.amount = fx(90 * ($signed($urandom_range(0, 8)) - 4));
        else
        begin
            case ($urandom_range(0, 4))
                0:       req.amount = AMT_MAX;
                1:       req.amount = AMT_MIN;
                2:       req.amount = 32'sd1;
                3:       req.amount = -32'sd1;
                default: req.amount = 32'sd0;
            endcase
        end
        return req;
    endfunction

    // One register write request on the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_START_X:       home_x = val;
            CFG_START_Y:       home_y = val;
            CFG_START_HEADING: home_heading = val;
            default: ;
        endcase
    endtask

    // Wait until every command is sent and every result has come back.
    task automatic wait_idle(input int settle);
        do @(posedge clk);
        while (cmd_backlog.size() != 0 || in_valid || turtle_results_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Driver: bursts of command requests separated by random gaps.
    always @(posedge clk)
    begin : drive_commands
        logic next_valid;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                turtle_results_due.push_back(step_turtle(in_data));
            if (!in_valid || in_ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_backlog.size() > 0)
                begin
                    next_valid = 1'b1;
                    in_data <= cmd_backlog.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // Monitor: compare each accepted result request with the oldest one owed.
    always @(posedge clk)
    begin : watch_results
        tge_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (turtle_results_due.size() == 0)
                    log_failure({"Unexpected result: ", res_text(out_data)});
                else
                begin
                    want = turtle_results_due.pop_front();
                    results_checked++;
                    if (out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
                        out_data.direction !== want.direction ||
                        out_data.pen_is_lowered !== want.pen_is_lowered ||
                        out_data.line_valid !== want.line_valid ||
                        out_data.line_from_x !== want.line_from_x ||
                        out_data.line_from_y !== want.line_from_y ||
                        out_data.saturated !== want.saturated)
                        log_failure($sformatf("Result %0d mismatch\n  expected %s\n  actual   %s",
                                              results_checked, res_text(want),
                                              res_text(out_data)));
                end
            end
            // Receiver alternates open runs with short or long stalls.
            if (hold_cnt == 0)
            begin
                rx_open  = !rx_open;
                hold_cnt = rx_open ? $urandom_range(1, 40) :
                           (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 6));
            end
            else
                hold_cnt--;
            out_ready <= rx_open;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_turtle_graphics_engine_unit NOT OK");
        $finish;
    end

    initial
    begin : run_phases
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic [31:0]        set_h;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands with the reset home values.
        queue_cmd(ACT_FORWARD, 32'sd0);
        queue_cmd(ACT_FORWARD, fx(10));
        queue_cmd(ACT_RIGHT, fx(90));
        queue_cmd(ACT_FORWARD, fx(3) + 32'sh8000);
        queue_cmd(ACT_RIGHT, fx(90));
        queue_cmd(ACT_BACKWARD, fx(7));
        queue_cmd(ACT_LEFT, fx(45));
        queue_cmd(ACT_LEFT, AMT_MIN);
        queue_cmd(ACT_RIGHT, AMT_MAX);
        queue_cmd(ACT_RIGHT, -32'sd1);
        queue_cmd(ACT_PEN_UP, 32'sd0);
        queue_cmd(ACT_FORWARD, fx(100));
        queue_cmd(ACT_BACKWARD, AMT_MIN);
        queue_cmd(ACT_PEN_DOWN, $urandom);
        queue_cmd(ACT_FORWARD, AMT_MAX);
        queue_cmd(ACT_FORWARD, AMT_MAX);
        queue_cmd(ACT_BACKWARD, AMT_MAX);
        queue_cmd(ACT_FORWARD, AMT_MIN);
        queue_cmd(ACT_BACKWARD, AMT_MIN);
        queue_cmd(ACT_UNUSED, $urandom);
        queue_cmd(ACT_HOME, $urandom);
        queue_cmd(ACT_LEFT, fx(-30));
        queue_cmd(ACT_FORWARD, -fx(5));
        queue_cmd(ACT_PEN_UP, $urandom);
        queue_cmd(ACT_HOME, 32'sd0);
        wait_idle(4);

        // Random phases, each under its own home setting.
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    set_x = AMT_MAX;
                    set_y = AMT_MIN;
                    set_h = 32'hFFFF_FFFF;
                end
                1:
                begin
                    set_x = AMT_MIN;
                    set_y = AMT_MAX;
                    set_h = 32'h4000_0000;
                end
                2:
                begin
                    set_x = '0;
                    set_y = '0;
                    set_h = 32'h8000_0000;
                end
                default:
                begin
                    set_x = $urandom;
                    set_y = $urandom;
                    set_h = $urandom;
                end
            endcase
            write_reg(CFG_START_X, set_x);
            write_reg(CFG_START_Y, set_y);
            write_reg(CFG_START_HEADING, set_h);
            // The spare index must leave the home registers alone.
            if (p % 2 == 1)
                write_reg(CFG_SPARE_IDX, $urandom);
            queue_cmd(ACT_HOME, $urandom);
            queue_cmd(ACT_FORWARD, AMT_MAX);
            for (int n = 0; n < RANDOM_PER_SET; n++)
                cmd_backlog.push_back(random_cmd());
            wait_idle(4);
        end

        wait_idle(40);
        $display("Sent %0d commands: %0d moves, %0d drawn segments, %0d clipped moves.",
                 cmds_sent, moves_sent, segments_drawn, clipped_moves);
        $display("Checked %0d results across %0d register writes, %0d failures.",
                 results_checked, reg_writes, fail_count);
        if (fail_count == 0 && turtle_results_due.size() == 0)
            $display("tb_turtle_graphics_engine_unit OK");
        else
            $display("tb_turtle_graphics_engine_unit NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tge_pkg.sv
rtl/tge_ctrl.sv
rtl/tge_datapath.sv
rtl/turtle_graphics_engine_unit.sv
rtl/tge_checker.sv
tb/tb_turtle_graphics_engine_unit.sv
